### src/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table.
// Used by dvrt_ctrl, dvrt_dp and the top level; depends on nothing.
package dvrt_pkg;

   localparam int NODES     = 16;
   localparam int IDX_BITS  = 4;
   localparam int COST_BITS = 16;
   localparam int KIND_BITS = 3;
   localparam int FAIL_BITS = 5;

   localparam logic [COST_BITS-1:0] COST_INF = '1;

   // Request kinds.
   localparam logic [KIND_BITS-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_ENTRY  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_COST   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 3'd4;

   // Register indexes of the configuration port.
   localparam logic REG_OWN_NODE = 1'b0;
   localparam logic REG_TIMEOUT  = 1'b1;

   // Command from controller to datapath, one step per cycle.
   typedef struct packed {
      logic                latch;
      logic                exec;
      logic                scan_link;
      logic                scan_route;
      logic                scan_cost;
      logic                publish;
      logic [IDX_BITS-1:0] idx;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 cost_go;
      logic                 rsp_free;
   } status_type;

endpackage

### src/dvrt_ctrl.sv
// Controller state machine for the distance-vector route table.
// Depends on dvrt_pkg; drives the datapath dvrt_dp by command and status.
module dvrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dvrt_pkg::status_type   status,
   output dvrt_pkg::cmd_type      cmd
);
   import dvrt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCANL = 3'd2;
   localparam logic [2:0] S_SCANR = 3'd3;
   localparam logic [2:0] S_SCANC = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(NODES - 1);

   logic [2:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and scan index.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            idx_in = '0;
            if (status.kind == KIND_TICK) begin
               state_in = S_SCANL;
            end else if (status.kind == KIND_COST && status.cost_go) begin
               state_in = S_SCANC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCANL: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) state_in = S_SCANR;
         end
         S_SCANR, S_SCANC: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands for the current state.
   always_comb begin
      cmd            = '0;
      cmd.idx        = idx_ff;
      cmd.latch      = (state_ff == S_IDLE) && req_tvalid;
      cmd.exec       = (state_ff == S_EXEC);
      cmd.scan_link  = (state_ff == S_SCANL);
      cmd.scan_route = (state_ff == S_SCANR);
      cmd.scan_cost  = (state_ff == S_SCANC);
      cmd.publish    = (state_ff == S_DONE) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // A result is only published into a free output slot.
   assert property (@(posedge clock) disable iff (reset) cmd.publish |-> status.rsp_free)
      else $error("publish into occupied output slot");

   // Every scan starts at entry zero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (idx_ff == '0))
      else $error("scan did not start at entry zero");

   // The state register only holds defined states.
   assert property (@(posedge clock) disable iff (reset) state_ff <= S_DONE)
      else $error("undefined controller state");

endmodule

### src/dvrt_dp.sv
// Datapath of the distance-vector route table: route and link tables,
// item registers, per-entry update logic and the result register. Uses dvrt_pkg.
module dvrt_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  dvrt_pkg::cmd_type                cmd,
   output dvrt_pkg::status_type             status,
   input  logic [dvrt_pkg::KIND_BITS-1:0]   in_kind,
   input  logic [dvrt_pkg::IDX_BITS-1:0]    in_peer,
   input  logic [dvrt_pkg::IDX_BITS-1:0]    in_target,
   input  logic [dvrt_pkg::COST_BITS-1:0]   in_cost_value,
   input  logic [dvrt_pkg::IDX_BITS-1:0]    in_peer_hop,
   input  logic                             in_peer_hop_valid,
   input  logic [dvrt_pkg::IDX_BITS-1:0]    own_node,
   input  logic [7:0]                       timeout_ticks,
   input  logic                             own_wr,
   input  logic [dvrt_pkg::IDX_BITS-1:0]    own_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_changed,
   output logic [dvrt_pkg::IDX_BITS-1:0]    rsp_hop_out,
   output logic                             rsp_hop_out_valid,
   output logic [dvrt_pkg::COST_BITS-1:0]   rsp_cost_out,
   output logic [dvrt_pkg::FAIL_BITS-1:0]   rsp_links_failed
);
   import dvrt_pkg::*;

   // Route and link tables.
   logic [IDX_BITS-1:0]  route_hop_ff  [NODES];
   logic [NODES-1:0]     route_valid_ff;
   logic [COST_BITS-1:0] route_cost_ff [NODES];
   logic [NODES-1:0]     link_present_ff;
   logic [NODES-1:0]     link_up_ff;
   logic [COST_BITS-1:0] link_cost_ff  [NODES];
   logic [15:0]          heard_ff      [NODES];
   logic [15:0]          tick_ff;

   // Current item.
   logic [KIND_BITS-1:0] kind_ff;
   logic [IDX_BITS-1:0]  peer_ff, target_ff, phop_ff;
   logic [COST_BITS-1:0] cv_ff;
   logic                 phopv_ff;

   // Work registers of the item.
   logic                 ch_ff;
   logic [FAIL_BITS-1:0] fail_cnt_ff;
   logic [NODES-1:0]     mask_ff;
   logic [COST_BITS-1:0] old_cost_ff;
   logic [IDX_BITS-1:0]  hop_o_ff;
   logic                 hv_o_ff;
   logic [COST_BITS-1:0] cost_o_ff;

   // Output register.
   logic                 rsp_valid_ff;
   logic                 rsp_changed_ff;
   logic [IDX_BITS-1:0]  rsp_hop_ff;
   logic                 rsp_hv_ff;
   logic [COST_BITS-1:0] rsp_cost_ff;
   logic [FAIL_BITS-1:0] rsp_fail_ff;

   logic [IDX_BITS-1:0]  ra, la;
   logic [IDX_BITS-1:0]  r_hop;
   logic                 r_v;
   logic [COST_BITS-1:0] r_cost;
   logic                 l_pres, l_up;
   logic [COST_BITS-1:0] l_cost;
   logic [15:0]          l_heard;
   logic                 peer_ok, entry_go, cost_go_in, link_fails;
   logic [COST_BITS:0]   cand_sum, cand, shift_sum;
   logic                 rw_en;
   logic [IDX_BITS-1:0]  rw_hop_raw, rw_hop;
   logic [COST_BITS:0]   rw_cost_raw;
   logic [COST_BITS-1:0] rw_cost;
   logic                 rw_v, rw_diff;
   logic [15:0]          silence;
   logic [NODES-1:0]     own_ok, entry_ok;

   // Table read ports: one route address and one link address per cycle.
   always_comb begin
      if (cmd.exec) begin
         ra = (kind_ff == KIND_ENTRY || kind_ff == KIND_LOOKUP) ? target_ff : peer_ff;
         la = peer_ff;
      end else begin
         ra = cmd.idx;
         la = cmd.idx;
      end
      r_hop   = route_hop_ff[ra];
      r_v     = route_valid_ff[ra];
      r_cost  = route_cost_ff[ra];
      l_pres  = link_present_ff[la];
      l_up    = link_up_ff[la];
      l_cost  = link_cost_ff[la];
      l_heard = heard_ff[la];
   end

   assign peer_ok    = (peer_ff != own_node);
   assign entry_go   = peer_ok && l_pres;
   assign cost_go_in = peer_ok && l_pres;
   assign silence    = tick_ff - l_heard;
   assign link_fails = l_pres && l_up && (silence > {8'd0, timeout_ticks});

   // Saturating candidate cost of a neighbor entry.
   always_comb begin
      cand_sum = {1'b0, l_cost} + {1'b0, cv_ff};
      if (l_cost == COST_INF || cv_ff == COST_INF || cand_sum >= {1'b0, COST_INF}) begin
         cand = {1'b0, COST_INF};
      end else begin
         cand = cand_sum;
      end
   end

   assign shift_sum = {1'b0, r_cost} + {1'b0, cv_ff};

   // Route update chosen for this step.
   always_comb begin
      rw_en       = 1'b0;
      rw_hop_raw  = peer_ff;
      rw_cost_raw = {1'b0, cv_ff};
      if (cmd.exec) begin
         case (kind_ff)
            KIND_ADD: begin
               rw_en = peer_ok && ((r_v && r_hop == peer_ff) || cv_ff < r_cost);
            end
            KIND_ENTRY: begin
               rw_cost_raw = cand;
               rw_en = entry_go && (target_ff != own_node) &&
                       ((r_v && r_hop == peer_ff) ||
                        (cand < {1'b0, r_cost} && !(phopv_ff && phop_ff == own_node))) &&
                       ({1'b0, r_cost} != cand);
            end
            default: rw_en = 1'b0;
         endcase
      end else if (cmd.scan_route) begin
         // Routes through a failed link fall back to a live direct link, else become infinite.
         rw_en = (cmd.idx != own_node) && r_v && mask_ff[r_hop];
         if ((cmd.idx != r_hop) && l_pres && l_up) begin
            rw_hop_raw  = cmd.idx;
            rw_cost_raw = {1'b0, l_cost};
         end else begin
            rw_hop_raw  = '0;
            rw_cost_raw = {1'b0, COST_INF};
         end
      end else if (cmd.scan_cost && cmd.idx != own_node) begin
         // Routes via the changed link shift by the difference; a cheaper direct link wins.
         if (r_v && r_hop == peer_ff) begin
            rw_en = 1'b1;
            if (cmd.idx == peer_ff || cv_ff == COST_INF) begin
               rw_cost_raw = {1'b0, cv_ff};
            end else if (shift_sum > {1'b0, old_cost_ff}) begin
               rw_cost_raw = shift_sum - {1'b0, old_cost_ff};
            end else begin
               rw_cost_raw = '0;
            end
         end else if (cmd.idx == peer_ff && r_cost > cv_ff) begin
            rw_en = 1'b1;
         end
      end
   end

   // Infinite routes carry no next hop.
   always_comb begin
      if (rw_cost_raw >= {1'b0, COST_INF}) begin
         rw_hop  = '0;
         rw_v    = 1'b0;
         rw_cost = COST_INF;
      end else begin
         rw_hop  = rw_hop_raw;
         rw_v    = 1'b1;
         rw_cost = rw_cost_raw[COST_BITS-1:0];
      end
      rw_diff = rw_en && (rw_hop != r_hop || rw_v != r_v || rw_cost != r_cost);
   end

   // Item registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff   <= in_kind;
         peer_ff   <= in_peer;
         target_ff <= in_target;
         cv_ff     <= in_cost_value;
         phop_ff   <= in_peer_hop;
         phopv_ff  <= in_peer_hop_valid;
      end
   end

   // Work registers and lookup answer.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ch_ff       <= rw_diff;
         fail_cnt_ff <= '0;
         mask_ff     <= '0;
         old_cost_ff <= l_cost;
         if (kind_ff == KIND_LOOKUP) begin
            hop_o_ff  <= r_hop;
            hv_o_ff   <= r_v;
            cost_o_ff <= r_cost;
         end else begin
            hop_o_ff  <= '0;
            hv_o_ff   <= 1'b0;
            cost_o_ff <= '0;
         end
      end else begin
         if (rw_diff) ch_ff <= 1'b1;
         if (cmd.scan_link && link_fails) begin
            mask_ff[cmd.idx] <= 1'b1;
            fail_cnt_ff      <= fail_cnt_ff + 1'b1;
         end
      end
   end

   // Route and link tables.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            route_hop_ff[i]  <= '0;
            route_cost_ff[i] <= (i == 0) ? COST_BITS'(0) : COST_INF;
            link_cost_ff[i]  <= COST_INF;
            heard_ff[i]      <= '0;
         end
         route_valid_ff    <= NODES'(1);
         link_present_ff   <= '0;
         link_up_ff        <= '0;
         tick_ff           <= '0;
      end else begin
         if (rw_en) begin
            route_hop_ff[ra]   <= rw_hop;
            route_valid_ff[ra] <= rw_v;
            route_cost_ff[ra]  <= rw_cost;
         end
         if (cmd.exec) begin
            case (kind_ff)
               KIND_ADD: begin
                  if (peer_ok) begin
                     link_present_ff[la] <= 1'b1;
                     link_up_ff[la]      <= 1'b1;
                     link_cost_ff[la]    <= cv_ff;
                     heard_ff[la]        <= tick_ff;
                  end
               end
               KIND_ENTRY: begin
                  if (entry_go) begin
                     link_up_ff[la] <= 1'b1;
                     heard_ff[la]   <= tick_ff;
                  end
               end
               KIND_TICK: tick_ff <= tick_ff + 1'b1;
               KIND_COST: begin
                  if (cost_go_in) link_cost_ff[la] <= cv_ff;
               end
               default: ;
            endcase
         end
         if (cmd.scan_link && link_fails) link_up_ff[la] <= 1'b0;
         // A new own node gets its zero-cost route.
         if (own_wr) begin
            route_hop_ff[own_wdata]   <= own_wdata;
            route_valid_ff[own_wdata] <= 1'b1;
            route_cost_ff[own_wdata]  <= '0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_changed_ff <= ch_ff;
         rsp_hop_ff     <= hop_o_ff;
         rsp_hv_ff      <= hv_o_ff;
         rsp_cost_ff    <= cost_o_ff;
         rsp_fail_ff    <= (kind_ff == KIND_TICK) ? fail_cnt_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_hop_out       = rsp_hop_ff;
   assign rsp_hop_out_valid = rsp_hv_ff;
   assign rsp_cost_out      = rsp_cost_ff;
   assign rsp_links_failed  = rsp_fail_ff;

   assign status.kind     = kind_ff;
   assign status.cost_go  = cost_go_in;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // Consistency flags for the checks below.
   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         entry_ok[i] = (route_valid_ff[i] == (route_cost_ff[i] != COST_INF)) &&
                       (route_valid_ff[i] || route_hop_ff[i] == '0);
         own_ok[i]   = (IDX_BITS'(i) != own_node) ||
                       (route_valid_ff[i] && route_cost_ff[i] == '0);
      end
   end

   // A route is valid exactly when its cost is finite.
   assert property (@(posedge clock) disable iff (reset) &entry_ok)
      else $error("route entry validity and cost disagree");

   // The own route stays valid at cost zero.
   assert property (@(posedge clock) disable iff (reset) &own_ok)
      else $error("own route lost");

   // A stalled result stays valid with its cost and next hop unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=>
         (rsp_valid_ff && $stable(rsp_cost_ff) && $stable(rsp_hop_ff)))
      else $error("stalled result changed");

endmodule

### src/distance_vector_route_table_core.sv
// Distance-vector route table: top level with the configuration registers.
// Instantiates dvrt_ctrl and dvrt_dp; uses dvrt_pkg.
//
// One request is worked on at a time. Add-link, neighbor-entry and lookup
// requests go from acceptance through execution to the result; a cost change
// on a present link walks all sixteen route entries; a tick walks the link
// table and then the route table, one entry per cycle each. A finished result
// waits in the output register while the next request is accepted. Register 0
// (own_node, byte address 0) and register 1 (timeout_ticks, address 4) are to be
// written by the user only while the block is idle; the block does not enforce this.
module distance_vector_route_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // peer[3:0], target[7:4], cost_value[23:8],
                                   // peer_hop[27:24], peer_hop_valid[28], zero fill
   input  logic [2:0]  req_tuser,  // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // changed[0], hop_out[4:1], hop_out_valid[5],
                                   // cost_out[21:6], links_failed[26:22], zero fill
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dvrt_pkg::*;

   logic [IDX_BITS-1:0]  own_ff, own_in;
   logic [7:0]           timeout_ff, timeout_in;
   logic                 csr_wr, own_wr;
   cmd_type              cmd;
   status_type           status;
   logic                 rsp_changed, rsp_hv;
   logic [IDX_BITS-1:0]  rsp_hop;
   logic [COST_BITS-1:0] rsp_cost;
   logic [FAIL_BITS-1:0] rsp_fail;

   // Configuration register writes and reads.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign own_wr     = csr_wr && (csr_paddr[2] == REG_OWN_NODE);

   always_comb begin
      own_in     = own_ff;
      timeout_in = timeout_ff;
      if (own_wr) own_in = csr_pwdata[IDX_BITS-1:0];
      if (csr_wr && csr_paddr[2] == REG_TIMEOUT) timeout_in = csr_pwdata[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff     <= '0;
         timeout_ff <= 8'd3;
      end else begin
         own_ff     <= own_in;
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_OWN_NODE: csr_prdata = {{(32-IDX_BITS){1'b0}}, own_ff};
         REG_TIMEOUT:  csr_prdata = {24'd0, timeout_ff};
         default:      csr_prdata = '0;
      endcase
   end

   dvrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dvrt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_kind           (req_tuser),
      .in_peer           (req_tdata[3:0]),
      .in_target         (req_tdata[7:4]),
      .in_cost_value     (req_tdata[23:8]),
      .in_peer_hop       (req_tdata[27:24]),
      .in_peer_hop_valid (req_tdata[28]),
      .own_node          (own_ff),
      .timeout_ticks     (timeout_ff),
      .own_wr            (own_wr),
      .own_wdata         (csr_pwdata[IDX_BITS-1:0]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_changed       (rsp_changed),
      .rsp_hop_out       (rsp_hop),
      .rsp_hop_out_valid (rsp_hv),
      .rsp_cost_out      (rsp_cost),
      .rsp_links_failed  (rsp_fail)
   );

   assign rsp_tdata = {5'd0, rsp_fail, rsp_cost, rsp_hv, rsp_hop, rsp_changed};

endmodule

### sim/testbench.sv
// Testbench for the distance-vector route table core: directed and random requests,
// with an in-bench route table predictor and a scoreboard. Uses dvrt_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dvrt_pkg::*;

   typedef struct packed {
      logic [4:0]  failed;
      logic [15:0] cost;
      logic        hop_valid;
      logic [3:0]  hop;
      logic        changed;
   } route_reply_type;

   // Predicted route table state and the queue of predicted replies.
   class route_scoreboard_type;
      logic [3:0]  r_hop[16];
      logic        r_valid[16];
      logic [15:0] r_cost[16];
      logic        l_present[16];
      logic        l_up[16];
      logic [15:0] l_cost[16];
      logic [15:0] heard[16];
      logic [15:0] ticks;
      logic [3:0]  own;
      logic [7:0]  timeout;
      route_reply_type pending[$];
      int errors;

      function void clear();
         own = 0; timeout = 3; ticks = 0; errors = 0;
         for (int i = 0; i < 16; i++) begin
            r_hop[i] = 0; r_valid[i] = 0; r_cost[i] = COST_INF;
            l_present[i] = 0; l_up[i] = 0; l_cost[i] = COST_INF; heard[i] = 0;
         end
         r_valid[0] = 1; r_cost[0] = 0;
      endfunction

      function void write_reg(int idx, logic [31:0] val);
         if (idx == 0) begin
            own = val[3:0];
            r_hop[own] = own; r_valid[own] = 1; r_cost[own] = 0;
         end else timeout = val[7:0];
      endfunction

      function bit put_route(int i, logic [3:0] hop, logic [16:0] cost);
         logic v;
         bit d;
         v = 1;
         if (cost >= COST_INF) begin
            cost = COST_INF; hop = 0; v = 0;
         end
         d = r_hop[i] != hop || r_valid[i] != v || r_cost[i] != cost[15:0];
         r_hop[i] = hop; r_valid[i] = v; r_cost[i] = cost[15:0];
         return d;
      endfunction

      function bit goes_via(int i, logic [3:0] p);
         return r_valid[i] && r_hop[i] == p;
      endfunction

      // Predicts the reply for one accepted request.
      function void note_request(logic [2:0] kind, logic [3:0] peer, logic [3:0] tgt,
                                 logic [15:0] cv, logic [3:0] phop, logic phv);
         route_reply_type r;
         bit ok;
         logic [16:0] cand, s;
         logic [15:0] old;
         r = '0;
         ok = peer != own;
         if (kind == KIND_ADD && ok) begin
            l_present[peer] = 1; l_up[peer] = 1; l_cost[peer] = cv; heard[peer] = ticks;
            if (goes_via(peer, peer) || cv < r_cost[peer])
               r.changed = put_route(peer, peer, {1'b0, cv});
         end else if (kind == KIND_ENTRY && ok && l_present[peer]) begin
            cand = l_cost[peer] + cv;
            if (l_cost[peer] == COST_INF || cv == COST_INF || cand >= COST_INF)
               cand = COST_INF;
            l_up[peer] = 1; heard[peer] = ticks;
            if (tgt != own && (goes_via(tgt, peer) ||
                (cand < r_cost[tgt] && !(phv && phop == own))) && r_cost[tgt] != cand)
               r.changed = put_route(tgt, peer, cand);
         end else if (kind == KIND_TICK) begin
            ticks = ticks + 1;
            for (int a = 0; a < 16; a++) begin
               if (l_present[a] && l_up[a] && 16'(ticks - heard[a]) > timeout) begin
                  l_up[a] = 0;
                  r.failed++;
                  for (int i = 0; i < 16; i++) begin
                     if (i == own || !goes_via(i, a)) continue;
                     if (i != a && l_present[i] && l_up[i])
                        r.changed |= put_route(i, i, {1'b0, l_cost[i]});
                     else
                        r.changed |= put_route(i, 0, COST_INF);
                  end
               end
            end
         end else if (kind == KIND_COST && ok && l_present[peer]) begin
            old = l_cost[peer];
            l_cost[peer] = cv;
            for (int i = 0; i < 16; i++) begin
               if (i == own) continue;
               if (goes_via(i, peer)) begin
                  if (i == peer || cv == COST_INF) s = cv;
                  else begin
                     s = r_cost[i] + cv;
                     s = s > old ? s - old : 0;
                  end
                  r.changed |= put_route(i, peer, s);
               end else if (i == peer && r_cost[i] > cv)
                  r.changed |= put_route(i, peer, {1'b0, cv});
            end
         end else if (kind == KIND_LOOKUP) begin
            r.hop = r_hop[tgt]; r.hop_valid = r_valid[tgt]; r.cost = r_cost[tgt];
         end
         pending = {pending, r};
      endfunction

      function void check_reply(logic [31:0] data);
         route_reply_type got, exp;
         got = data[26:0];
         if (pending.size() == 0) begin
            $display("%0t: unexpected reply %h", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got !== exp || data[31:27] !== 0) begin
            $display("%0t: reply mismatch expected %h actual %h", $time, exp, data);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic [31:0] req_tdata = 0;
   logic [2:0] req_tuser = 0;
   logic req_tready, rsp_tvalid, csr_pready;
   logic [31:0] rsp_tdata, csr_prdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   route_scoreboard_type board = new();
   int cycles = 0;
   bit calm = 0;

   distance_vector_route_table_core uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Cycle limit for the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Reply side: random stalls, checks each accepted reply.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_reply(rsp_tdata);
         rsp_tready <= calm || $urandom_range(99) >= 21;
      end
   end

   task automatic write_csr(int idx, logic [31:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 3'(4 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.write_reg(idx, val);
   endtask

   task automatic send_request(logic [2:0] kind, logic [3:0] peer, logic [3:0] tgt,
                               logic [15:0] cv, logic [3:0] phop, logic phv);
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {3'b0, phv, phop, cv, tgt, peer};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, peer, tgt, cv, phop, phv);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_cost();
      case ($urandom_range(9))
         0: return COST_INF;
         1: return 16'hFFFE;
         2: return 16'd0;
         3: return 16'($urandom);
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic random_request();
      logic [2:0] k;
      int w;
      w = $urandom_range(99);
      if (w < 25) k = KIND_ENTRY;
      else if (w < 40) k = KIND_ADD;
      else if (w < 55) k = KIND_TICK;
      else if (w < 65) k = KIND_COST;
      else if (w < 97) k = KIND_LOOKUP;
      else k = 3'($urandom_range(5, 7));
      send_request(k, 4'($urandom), 4'($urandom), pick_cost(), 4'($urandom),
                   1'($urandom));
   endtask

   initial begin
      board.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: links, adverts, loop avoidance, cost change, timeouts, lookups.
      send_request(KIND_ADD, 1, 0, 5, 0, 0);
      send_request(KIND_ADD, 2, 0, 16'hFFFE, 0, 0);
      send_request(KIND_ADD, 0, 0, 1, 0, 0);
      send_request(KIND_ENTRY, 1, 7, 10, 3, 1);
      send_request(KIND_ENTRY, 2, 8, 4, 0, 1);
      send_request(KIND_ENTRY, 1, 8, 20, 0, 1);
      send_request(KIND_ENTRY, 1, 9, COST_INF, 15, 1);
      send_request(KIND_ENTRY, 3, 9, 1, 0, 0);
      send_request(KIND_ENTRY, 1, 0, 1, 0, 0);
      send_request(KIND_COST, 1, 0, 2, 0, 0);
      send_request(KIND_COST, 1, 0, COST_INF, 0, 0);
      send_request(KIND_COST, 1, 0, 1, 0, 0);
      send_request(KIND_LOOKUP, 0, 7, 0, 0, 0);
      send_request(KIND_LOOKUP, 0, 15, 0, 0, 0);
      for (int i = 0; i < 5; i++) send_request(KIND_TICK, 0, 0, 0, 0, 0);
      send_request(KIND_LOOKUP, 0, 1, 0, 0, 0);
      send_request(KIND_ADD, 15, 0, 0, 0, 0);
      send_request(3'd7, 15, 15, 16'hFFFF, 15, 1);
      send_request(KIND_LOOKUP, 0, 15, 0, 0, 0);
      // Pause until every reply is back, then run through register settings.
      drain();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin write_csr(0, 15); write_csr(1, 1); end
            1: begin write_csr(0, 0); write_csr(1, 255); end
            2: begin write_csr(0, 5); write_csr(1, 2); end
            3: begin write_csr(0, 10); write_csr(1, 0); end
            default: begin write_csr(0, 3); write_csr(1, 4); end
         endcase
         calm = (phase == 2);
         for (int n = 0; n < 400; n++) random_request();
         drain();
      end
      if (board.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

### sim.f
src/dvrt_pkg.sv
src/dvrt_ctrl.sv
src/dvrt_dp.sv
src/distance_vector_route_table_core.sv
sim/testbench.sv
